### hdl/bce_pkg.sv
// bce_pkg: widths, command codes and the request type shared by the binomial coefficient engine
// depends on nothing; imported by the channel interfaces, the multiply-divide unit and the top level
package bce_pkg;

    localparam int COEF_W = 60;            // coefficient width
    localparam int IDX_W  = 6;             // row, column and position width
    localparam int MULT_W = 6;             // numerator term n - i
    localparam int DIV_W  = 7;             // denominator term i + 1, up to 64
    localparam int PROD_W = COEF_W + MULT_W; // full product never overflows
    localparam int CNT_W  = 7;             // bit counter over the PROD_W bits of each phase

    localparam logic [CNT_W-1:0] LAST_BIT = CNT_W'(PROD_W - 1);

    // command codes on the cmd channel
    typedef enum logic
    {
        CMD_SINGLE = 1'b0,
        CMD_ROW    = 1'b1
    } bce_cmd_t;

    // request from the sequencer to the serial multiply-divide unit
    typedef struct packed {
        logic              start;
        logic [MULT_W-1:0] mult;
        logic [DIV_W-1:0]  divisor;
    } bce_req_t;

endpackage

### hdl/bce_cmd_if.sv
// bce_cmd_if: command channel, valid/ready handshake with command, row and column
// depends on bce_pkg
interface bce_cmd_if
    import bce_pkg::*;
;
    logic             valid;
    logic             ready;
    logic             command;
    logic [IDX_W-1:0] row_index;
    logic [IDX_W-1:0] column_index;

    modport source (output valid, output command, output row_index, output column_index,
                    input ready);
    modport sink   (input valid, input command, input row_index, input column_index,
                    output ready);
endinterface

### hdl/bce_res_if.sv
// bce_res_if: result channel, valid/ready handshake with coefficient, position and last
// depends on bce_pkg
interface bce_res_if
    import bce_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [COEF_W-1:0] coefficient;
    logic [IDX_W-1:0]  position;
    logic              last;

    modport source (output valid, output coefficient, output position, output last,
                    input ready);
    modport sink   (input valid, input coefficient, input position, input last,
                    output ready);
endinterface

### hdl/bce_mul_div.sv
// bce_mul_div: bit-serial exact (v * m) / d, serial multiply then restoring divide
// depends on bce_pkg
module bce_mul_div
    import bce_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  bce_req_t          req,
    input  logic [COEF_W-1:0] operand,
    output logic              done,
    output logic [COEF_W-1:0] result
);

    typedef enum logic [2:0] {
        PH_IDLE = 3'b001,
        PH_MUL  = 3'b010,
        PH_DIV  = 3'b100
    } phase_t;

    phase_t            phase_reg, phase_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              done_reg, done_next;
    logic [PROD_W-1:0] acc_reg, acc_next;
    logic [MULT_W-1:0] carry_reg, carry_next;
    logic [MULT_W-1:0] rem_reg, rem_next;
    logic [MULT_W-1:0] mult_reg, mult_next;
    logic [DIV_W-1:0]  div_reg, div_next;

    logic [MULT_W:0]   sum;
    logic [DIV_W-1:0]  trial;
    logic              q_bit;
    logic [DIV_W-1:0]  trial_diff;

    // one product bit per cycle, lsb first
    assign sum = (acc_reg[0] ? {1'b0, mult_reg} : '0) + {1'b0, carry_reg};

    // one quotient bit per cycle, msb first
    assign trial      = {rem_reg, acc_reg[PROD_W-1]};
    assign q_bit      = (trial >= div_reg);
    assign trial_diff = trial - div_reg;

    always_comb
    begin
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        acc_next   = acc_reg;
        carry_next = carry_reg;
        rem_next   = rem_reg;
        mult_next  = mult_reg;
        div_next   = div_reg;
        unique case (phase_reg)
            PH_IDLE:
            begin
                if (req.start)
                begin
                    phase_next = PH_MUL;
                    cnt_next   = '0;
                    acc_next   = {{MULT_W{1'b0}}, operand};
                    carry_next = '0;
                    mult_next  = req.mult;
                    div_next   = req.divisor;
                end
            end
            PH_MUL:
            begin
                acc_next   = {sum[0], acc_reg[PROD_W-1:1]};
                carry_next = sum[MULT_W:1];
                cnt_next   = cnt_reg + 1'b1;
                if (cnt_reg == LAST_BIT)
                begin
                    phase_next = PH_DIV;
                    cnt_next   = '0;
                    rem_next   = '0;
                end
            end
            PH_DIV:
            begin
                acc_next = {acc_reg[PROD_W-2:0], q_bit};
                rem_next = q_bit ? trial_diff[MULT_W-1:0] : trial[MULT_W-1:0];
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == LAST_BIT)
                begin
                    phase_next = PH_IDLE;
                    done_next  = 1'b1;
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg   <= acc_next;
        carry_reg <= carry_next;
        rem_reg   <= rem_next;
        mult_reg  <= mult_next;
        div_reg   <= div_next;
    end

    assign done   = done_reg;
    assign result = acc_reg[COEF_W-1:0];

endmodule

### hdl/binomial_coefficient_engine.sv
// binomial_coefficient_engine: command sequencer and output register around the serial unit
// depends on bce_pkg, bce_cmd_if, bce_res_if and bce_mul_div
//
// usage
//   cmd channel: one word per command. command 0 asks for C(row_index, column_index),
//   command 1 asks for the whole row C(row_index, 0) .. C(row_index, row_index).
//   a row_index above MAX_ROWS-1 is clamped to MAX_ROWS-1.
//   res channel: one word per coefficient with its column in position; last is set on
//   the final word of a command. command 0 always answers with one word, which is 0
//   when the column lies beyond the row.
//   one command at a time: cmd.ready is high only while the engine is idle, and it
//   rises again in the cycle after the final word is taken.
//   each multiplicative step (times n-i, exact divide by i+1) runs through a bit-serial
//   multiply-divide unit: shift-and-add over the product bits, then a restoring divide,
//   then a handoff back to the sequencer. C(n,k) takes k such steps; within a row the
//   next step starts only after the previous word is taken, so the receiver paces the row.
//   a stalled receiver holds the current word in the output register and freezes the
//   row; no word is dropped or repeated.
//   reset is asynchronous and active low; the engine comes back idle and ready, with
//   nothing on the result channel.
module binomial_coefficient_engine
    import bce_pkg::*;
#(
    parameter int MAX_ROWS = 64
)
(
    input  logic      clk,
    input  logic      rst_n,
    bce_cmd_if.sink   cmd,
    bce_res_if.source res
);

    localparam logic [IDX_W-1:0] ROW_MAX = IDX_W'(MAX_ROWS - 1);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_EVAL = 4'b0010,
        ST_SEND = 4'b0100,
        ST_CALC = 4'b1000
    } state_t;

    state_t            state_reg, state_next;
    logic [COEF_W-1:0] value_reg, value_next;   // running coefficient
    logic [IDX_W-1:0]  step_reg, step_next;     // steps done so far
    logic [IDX_W-1:0]  target_reg, target_next; // column or row end
    logic [IDX_W-1:0]  top_reg, top_next;       // clamped row n
    logic              mode_reg, mode_next;     // latched command
    logic [COEF_W-1:0] out_coef_reg, out_coef_next;
    logic [IDX_W-1:0]  out_pos_reg, out_pos_next;
    logic              out_last_reg, out_last_next;

    logic              cmd_take;
    logic              res_take;
    logic [IDX_W-1:0]  row_sat;
    logic              finished;
    bce_req_t          req;
    logic              unit_done;
    logic [COEF_W-1:0] unit_result;

    assign cmd_take = cmd.valid && cmd.ready;
    assign res_take = res.valid && res.ready;
    assign row_sat  = (cmd.row_index > ROW_MAX) ? ROW_MAX : cmd.row_index;
    assign finished = (step_reg == target_reg);

    always_comb
    begin
        state_next    = state_reg;
        value_next    = value_reg;
        step_next     = step_reg;
        target_next   = target_reg;
        top_next      = top_reg;
        mode_next     = mode_reg;
        out_coef_next = out_coef_reg;
        out_pos_next  = out_pos_reg;
        out_last_next = out_last_reg;
        req.start     = 1'b0;
        // next step multiplies by n - i and divides by i + 1
        req.mult      = top_reg - step_reg;
        req.divisor   = {1'b0, step_reg} + 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_take)
                begin
                    mode_next  = cmd.command;
                    top_next   = row_sat;
                    value_next = COEF_W'(1);
                    step_next  = '0;
                    if ((cmd.command == CMD_SINGLE) && (cmd.column_index > row_sat))
                    begin
                        // column beyond the row: a single zero word
                        target_next   = cmd.column_index;
                        out_coef_next = '0;
                        out_pos_next  = cmd.column_index;
                        out_last_next = 1'b1;
                        state_next    = ST_SEND;
                    end
                    else
                    begin
                        target_next = (cmd.command == CMD_ROW) ? row_sat : cmd.column_index;
                        state_next  = ST_EVAL;
                    end
                end
            end
            ST_EVAL:
            begin
                if ((mode_reg == CMD_ROW) || finished)
                begin
                    out_coef_next = value_reg;
                    out_pos_next  = step_reg;
                    out_last_next = finished;
                    state_next    = ST_SEND;
                end
                else
                begin
                    // single coefficient still short of its column
                    req.start  = 1'b1;
                    state_next = ST_CALC;
                end
            end
            ST_SEND:
            begin
                if (res_take)
                begin
                    if (out_last_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        req.start  = 1'b1;
                        state_next = ST_CALC;
                    end
                end
            end
            ST_CALC:
            begin
                if (unit_done)
                begin
                    value_next = unit_result;
                    step_next  = step_reg + 1'b1;
                    state_next = ST_EVAL;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg    <= value_next;
        step_reg     <= step_next;
        target_reg   <= target_next;
        top_reg      <= top_next;
        mode_reg     <= mode_next;
        out_coef_reg <= out_coef_next;
        out_pos_reg  <= out_pos_next;
        out_last_reg <= out_last_next;
    end

    bce_mul_div u_mul_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .operand (value_reg),
        .done    (unit_done),
        .result  (unit_result)
    );

    // handshake outputs
    assign cmd.ready       = (state_reg == ST_IDLE);
    assign res.valid       = (state_reg == ST_SEND);
    assign res.coefficient = out_coef_reg;
    assign res.position    = out_pos_reg;
    assign res.last        = out_last_reg;

endmodule

### hdl/bce_checker.sv
// bce_checker: port-level checks on the binomial coefficient engine, with its bind
// depends on bce_pkg and binomial_coefficient_engine
module bce_checker
    import bce_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              cmd_valid,
    input logic              cmd_ready,
    input logic              res_valid,
    input logic              res_ready,
    input logic [COEF_W-1:0] res_coefficient,
    input logic [IDX_W-1:0]  res_position,
    input logic              res_last
);

    // a stalled word holds
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_coefficient)
            && $stable(res_position) && $stable(res_last))
        else $error("stalled result word changed");

    // no new command while a word is on offer
    assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd_ready && res_valid))
        else $error("command taken while result pending");

    // a command closes the engine until its final word
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready |=> !cmd_ready)
        else $error("engine open right after a command");

    // the final word reopens the engine
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_ready && res_last |=> cmd_ready && !res_valid)
        else $error("engine not idle after final word");

    // a word that is not final keeps the engine closed
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_ready && !res_last |=> !cmd_ready)
        else $error("engine reopened in the middle of a row");

endmodule

bind binomial_coefficient_engine bce_checker u_bce_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd_valid       (cmd.valid),
    .cmd_ready       (cmd.ready),
    .res_valid       (res.valid),
    .res_ready       (res.ready),
    .res_coefficient (res.coefficient),
    .res_position    (res.position),
    .res_last        (res.last)
);
